### hdl/key_debounce_long_press_unit_defines.svh
// Assertion macros for the key debounce block
`ifndef KEY_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define KDLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kdlp assertion failed");
`define KDLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kdlp assertion failed");
`else
`define KDLP_ASSERT_NOW(label, ante, cons)
`define KDLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/kdlp_pkg.sv
`default_nettype none
package kdlp_pkg;

    localparam int KEY_SLOTS = 4;

    localparam logic [7:0] MS_PER_SAMPLE_RST      = 8'd5;
    localparam logic [3:0] SAMPLES_PER_WINDOW_RST = 4'd5;
    localparam logic [3:0] PRESS_VOTES_RST        = 4'd4;
    localparam logic [7:0] LONG_PRESS_WINDOWS_RST = 8'd40;

    localparam logic [3:0]  VOTE_MAX = 4'hF;
    localparam logic [7:0]  HOLD_MAX = 8'hFF;
    localparam logic [15:0] MS_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_MS_PER_SAMPLE      = 2'd0,
        CFG_SAMPLES_PER_WINDOW = 2'd1,
        CFG_PRESS_VOTES        = 2'd2,
        CFG_LONG_PRESS_WINDOWS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic sample;
        logic close;
    } kdlp_tick_t;

    typedef struct packed {
        logic        down;
        logic        pend;
        logic [15:0] ms;
    } kdlp_lane_t;

endpackage
`default_nettype wire

### hdl/kdlp_timebase.sv
`default_nettype none
module kdlp_timebase (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tick_en,
    input  wire logic [7:0]         ms_per_sample,
    input  wire logic [3:0]         samples_per_window,
    output kdlp_pkg::kdlp_tick_t    tick
);
    import kdlp_pkg::*;

    logic [7:0] div_reg, div_next, div_inc;
    logic [3:0] idx_reg, idx_next, idx_inc;

    always_comb begin
        div_inc     = div_reg + 8'd1;
        tick.sample = (div_inc >= ms_per_sample) || (div_inc == 8'd0);
        idx_inc     = idx_reg + 4'd1;
        tick.close  = tick.sample &&
                      ((idx_inc >= samples_per_window) || (idx_inc == 4'd0));
        div_next    = tick.sample ? 8'd0 : div_inc;
        idx_next    = idx_reg;
        if (tick.sample) begin
            idx_next = tick.close ? 4'd0 : idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= 8'd0;
            idx_reg <= 4'd0;
        end else if (tick_en) begin
            div_reg <= div_next;
            idx_reg <= idx_next;
        end
    end

endmodule
`default_nettype wire

### hdl/kdlp_lane.sv
`default_nettype none
`include "key_debounce_long_press_unit_defines.svh"
module kdlp_lane (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tick_en,
    input  wire kdlp_pkg::kdlp_tick_t tick,
    input  wire logic               level,
    input  wire logic               ack,
    input  wire logic [3:0]         press_votes,
    input  wire logic [7:0]         long_press_windows,
    output kdlp_pkg::kdlp_lane_t    lane_out
);
    import kdlp_pkg::*;

    logic [3:0]  vote_reg, vote_next;
    logic        down_reg, down_next;
    logic [7:0]  hold_reg, hold_next;
    logic        latch_reg, latch_next;
    logic        flag_reg, flag_next;
    logic [15:0] ms_reg, ms_next;

    always_comb begin
        flag_next  = flag_reg & ~ack;
        vote_next  = vote_reg;
        down_next  = down_reg;
        hold_next  = hold_reg;
        latch_next = latch_reg;
        if (tick.sample && !level && (vote_reg < VOTE_MAX)) begin
            vote_next = vote_reg + 4'd1;
        end
        if (tick.close) begin
            down_next = (vote_next >= press_votes);
            if (down_next) begin
                if (hold_reg < HOLD_MAX) begin
                    hold_next = hold_reg + 8'd1;
                end
                if (!latch_reg && (hold_next >= long_press_windows)) begin
                    latch_next = 1'b1;
                    flag_next  = 1'b1;
                end
            end else begin
                hold_next  = 8'd0;
                latch_next = 1'b0;
            end
            vote_next = 4'd0;
        end
        if (down_next) begin
            ms_next = (ms_reg < MS_MAX) ? ms_reg + 16'd1 : ms_reg;
        end else begin
            ms_next = 16'd0;
        end
        lane_out.down = down_next;
        lane_out.pend = flag_next;
        lane_out.ms   = ms_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_reg  <= 4'd0;
            down_reg  <= 1'b0;
            hold_reg  <= 8'd0;
            latch_reg <= 1'b0;
            flag_reg  <= 1'b0;
            ms_reg    <= 16'd0;
        end else if (tick_en) begin
            vote_reg  <= vote_next;
            down_reg  <= down_next;
            hold_reg  <= hold_next;
            latch_reg <= latch_next;
            flag_reg  <= flag_next;
            ms_reg    <= ms_next;
        end
    end

    `KDLP_ASSERT_NOW(a_flag_fires_with_latch, $rose(flag_reg), $rose(latch_reg))
    `KDLP_ASSERT_NOW(a_up_clears_ms, !down_reg, ms_reg == 16'd0)
    `KDLP_ASSERT_NOW(a_up_clears_hold, !down_reg, hold_reg == 8'd0)
    `KDLP_ASSERT_NOW(a_latch_needs_down, latch_reg, down_reg)

endmodule
`default_nettype wire

### hdl/kdlp_merge.sv
`default_nettype none
module kdlp_merge (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire kdlp_pkg::kdlp_lane_t lanes [kdlp_pkg::KEY_SLOTS],
    output logic                    load_ok,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_down_mask,
    output logic [3:0]              m_long_pending,
    output logic [15:0]             m_held_ms_key0,
    output logic [15:0]             m_held_ms_key1,
    output logic [15:0]             m_held_ms_key2,
    output logic [15:0]             m_held_ms_key3
);
    import kdlp_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  down_next, pend_next;

    always_comb begin
        for (int k = 0; k < KEY_SLOTS; k++) begin
            down_next[k] = lanes[k].down;
            pend_next[k] = lanes[k].pend;
        end
        load_ok    = !valid_reg || m_ready;
        valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_down_mask    <= down_next;
            m_long_pending <= pend_next;
            m_held_ms_key0 <= lanes[0].ms;
            m_held_ms_key1 <= lanes[1].ms;
            m_held_ms_key2 <= lanes[2].ms;
            m_held_ms_key3 <= lanes[3].ms;
        end
    end

    assign m_valid = valid_reg;

endmodule
`default_nettype wire

### hdl/key_debounce_long_press_unit.sv
// Four-key debouncer with a per-window vote threshold and one-shot long-press events.
// Input channel (s_valid/s_ready): one request per 1 ms tick, carrying the
// active-low key levels and a mask that acknowledges pending long-press events.
// Output channel (m_valid/m_ready): one result per tick with the debounced
// down mask, the pending long-press mask and the per-key held milliseconds.
// The result is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless the output stalls; per-key counters
// update together, one lane per key; the output register merges the lanes.
// A tick is accepted while the output register is empty or being drained,
// so a stalled receiver holds the result and back-pressures the input.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 ms_per_sample, 1 samples_per_window, 2 press_votes,
// 3 long_press_windows); write only while the block is idle.
// Reset: all counters, flags and the output valid clear; registers take
// their defaults 5, 5, 4 and 40.
`default_nettype none
module key_debounce_long_press_unit #(
    parameter int NUM_KEYS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_key_levels,
    input  wire logic [3:0]  s_long_ack,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_down_mask,
    output logic [3:0]       m_long_pending,
    output logic [15:0]      m_held_ms_key0,
    output logic [15:0]      m_held_ms_key1,
    output logic [15:0]      m_held_ms_key2,
    output logic [15:0]      m_held_ms_key3
);
    import kdlp_pkg::*;

    logic [7:0] ms_per_sample_reg;
    logic [3:0] samples_per_window_reg;
    logic [3:0] press_votes_reg;
    logic [7:0] long_press_windows_reg;

    logic       accept;
    logic       load_ok;
    kdlp_tick_t tick;
    kdlp_lane_t lanes [KEY_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_per_sample_reg      <= MS_PER_SAMPLE_RST;
            samples_per_window_reg <= SAMPLES_PER_WINDOW_RST;
            press_votes_reg        <= PRESS_VOTES_RST;
            long_press_windows_reg <= LONG_PRESS_WINDOWS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MS_PER_SAMPLE:      ms_per_sample_reg      <= cfg_wdata;
                CFG_SAMPLES_PER_WINDOW: samples_per_window_reg <= cfg_wdata[3:0];
                CFG_PRESS_VOTES:        press_votes_reg        <= cfg_wdata[3:0];
                CFG_LONG_PRESS_WINDOWS: long_press_windows_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_ready = load_ok;
    assign accept  = s_valid && load_ok;

    kdlp_timebase u_timebase (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .tick_en            (accept),
        .ms_per_sample      (ms_per_sample_reg),
        .samples_per_window (samples_per_window_reg),
        .tick               (tick)
    );

    for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_lane
        if (k < NUM_KEYS) begin : g_used
            kdlp_lane u_lane (
                .aclk               (aclk),
                .aresetn            (aresetn),
                .tick_en            (accept),
                .tick               (tick),
                .level              (s_key_levels[k]),
                .ack                (s_long_ack[k]),
                .press_votes        (press_votes_reg),
                .long_press_windows (long_press_windows_reg),
                .lane_out           (lanes[k])
            );
        end else begin : g_unused
            assign lanes[k] = '0;
        end
    end

    kdlp_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .lanes          (lanes),
        .load_ok        (load_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_down_mask    (m_down_mask),
        .m_long_pending (m_long_pending),
        .m_held_ms_key0 (m_held_ms_key0),
        .m_held_ms_key1 (m_held_ms_key1),
        .m_held_ms_key2 (m_held_ms_key2),
        .m_held_ms_key3 (m_held_ms_key3)
    );

endmodule
`default_nettype wire
